FILE: hw/rtl/ztp_pkg.sv
// shared constants and codes for the zone transition predictor
package ztp_pkg;

  localparam int ASSET_SLOTS_DEF = 256;
  localparam int EDGE_SLOTS_DEF  = 1024;
  localparam int MAX_GRID_DEF    = 64;

  localparam int ZONE_W  = 6;
  localparam int CELL_W  = 24;
  localparam int GRID_W  = 7;
  localparam int COUNT_W = 32;
  localparam int PROB_W  = 17;
  localparam int FRAC_W  = 16;

  localparam logic [1:0] KIND_UPDATE   = 2'd0;
  localparam logic [1:0] KIND_FINALIZE = 2'd1;
  localparam logic [1:0] KIND_PREDICT  = 2'd2;

  localparam logic REG_GRID_SIZE = 1'b0;
  localparam logic REG_CELL_SIZE = 1'b1;

  localparam logic [GRID_W-1:0] GRID_SIZE_RST = 7'd64;
  localparam logic [CELL_W-1:0] CELL_SIZE_RST = 24'd2560;

endpackage

FILE: hw/rtl/zone_transition_predictor.sv
// zone transition predictor: asset and edge tables with a shared serial divider
// Usage: configuration goes through the APB port, grid_size at byte address 0
// and cell_size at 4; write only while busy is low. A command word is taken
// when start is high and busy low. Kind 0 quantises x_pos/y_pos into a zone
// and counts a transition for a known asset or stores a new one, kind 1 turns
// edge counts into Q1.16 probabilities, kind 2 looks up the most probable next zone.
// Each command ends with one result word: done is high for exactly one cycle
// with the result fields; the receiver cannot hold it off, and busy drops in
// the same cycle so the next command may follow at once.
// Steps per command, one table entry read at a time, one divider of 48 steps:
//   update   divides x_pos, then y_pos, by cell_size, scans the assets, then the edges
//   predict  scans the assets, then the edges
//   finalize for each edge, sums the counts of all edges with its origin, then divides
// One command at a time; the table scans and the divider set how long each takes.
// After reset both tables are empty, registers hold 64 and 2560.
module zone_transition_predictor
  import ztp_pkg::*;
#(
  parameter int ASSET_SLOTS = ASSET_SLOTS_DEF,
  parameter int EDGE_SLOTS  = EDGE_SLOTS_DEF,
  parameter int MAX_GRID    = MAX_GRID_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            kind,
  input  logic [63:0]           asset_id,
  input  logic signed [31:0]    x_pos,
  input  logic signed [31:0]    y_pos,
  output logic                  done,
  output logic                  known,
  output logic [ZONE_W-1:0]     current_x,
  output logic [ZONE_W-1:0]     current_y,
  output logic [ZONE_W-1:0]     predicted_x,
  output logic [ZONE_W-1:0]     predicted_y,
  output logic [PROB_W-1:0]     confidence
);

  localparam int AW   = (ASSET_SLOTS > 1) ? $clog2(ASSET_SLOTS) : 1;
  localparam int AIW  = $clog2(ASSET_SLOTS + 1);
  localparam int EW   = (EDGE_SLOTS > 1) ? $clog2(EDGE_SLOTS) : 1;
  localparam int EIW  = $clog2(EDGE_SLOTS + 1);
  localparam int GMAX = (MAX_GRID < 64) ? MAX_GRID : 64;
  localparam int TW   = COUNT_W + EIW;
  localparam int DVW  = (TW > CELL_W) ? TW : CELL_W;
  localparam int NW   = COUNT_W + FRAC_W;
  localparam int CW   = $clog2(NW + 1);
  localparam int ZW   = 2 * ZONE_W;

  typedef enum logic [14:0] {
    S_IDLE    = 15'b000000000000001,
    S_DIVX    = 15'b000000000000010,
    S_DIVY    = 15'b000000000000100,
    S_ARD     = 15'b000000000001000,
    S_AMATCH  = 15'b000000000010000,
    S_ERD     = 15'b000000000100000,
    S_EMATCH  = 15'b000000001000000,
    S_FOUT_RD = 15'b000000010000000,
    S_FOUT_LD = 15'b000000100000000,
    S_FIN_RD  = 15'b000001000000000,
    S_FIN_ACC = 15'b000010000000000,
    S_FDIV    = 15'b000100000000000,
    S_PRD     = 15'b001000000000000,
    S_PMATCH  = 15'b010000000000000,
    S_SPARE   = 15'b100000000000000
  } state_t;

  state_t state;

  logic [GRID_W-1:0] grid_size;
  logic [CELL_W-1:0] cell_size;

  logic [1:0]  cmd_kind;
  logic [63:0] cmd_id;
  logic [31:0] cmd_x;
  logic [31:0] cmd_y;
  logic [ZONE_W-1:0] zone_x;
  logic [ZW-1:0] new_zone;
  logic [ZW-1:0] cur_zone;

  logic [AIW-1:0] asset_fill;
  logic [AIW-1:0] a_idx;
  logic [EIW-1:0] edge_fill;
  logic [EIW-1:0] e_idx;
  logic [EIW-1:0] e_j;

  logic [63:0]   asset_key [ASSET_SLOTS];
  logic [ZW-1:0] asset_zone [ASSET_SLOTS];
  logic [2*ZW-1:0]  edge_zones [EDGE_SLOTS];
  logic [COUNT_W-1:0] edge_count [EDGE_SLOTS];
  logic [PROB_W-1:0]  edge_prob [EDGE_SLOTS];

  logic [63:0]        key_q;
  logic [ZW-1:0]      azone_q;
  logic [2*ZW-1:0]    ezones_q;
  logic [COUNT_W-1:0] ecount_q;
  logic [PROB_W-1:0]  eprob_q;

  logic [AW-1:0] a_addr;
  logic [EW-1:0] e_addr;
  logic [EW-1:0] e_waddr;

  logic [ZW-1:0]      fin_origin;
  logic [COUNT_W-1:0] fin_count;
  logic [TW-1:0]      fin_total;

  logic [ZW-1:0]     best_zone;
  logic [PROB_W-1:0] best_prob;

  logic [DVW:0]    div_rem;
  logic [NW-1:0]   div_quo;
  logic [DVW-1:0]  div_d;
  logic [CW-1:0]   div_cnt;
  logic [DVW:0]    div_trial;
  logic            div_ge;

  logic [ZONE_W-1:0] top;
  logic [ZONE_W-1:0] zq;
  logic [31:0]       div_src;

  // register port
  assign pready = 1'b1;
  always_comb begin
    case (paddr[2])
      REG_GRID_SIZE: prdata = {{(32-GRID_W){1'b0}}, grid_size};
      REG_CELL_SIZE: prdata = {{(32-CELL_W){1'b0}}, cell_size};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= GRID_SIZE_RST;
      cell_size <= CELL_SIZE_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_GRID_SIZE: grid_size <= pwdata[GRID_W-1:0];
        REG_CELL_SIZE: cell_size <= pwdata[CELL_W-1:0];
        default: ;
      endcase
    end
  end

  // top zone index
  always_comb begin
    if (grid_size == '0) begin
      top = '0;
    end else if (grid_size > GRID_W'(GMAX)) begin
      top = ZONE_W'(GMAX - 1);
    end else begin
      top = ZONE_W'(grid_size - 7'd1);
    end
  end

  // quantise the coordinate just divided
  assign div_src = (state == S_DIVX) ? cmd_x : cmd_y;
  always_comb begin
    if (div_src[31] || div_src == '0) begin
      zq = '0;
    end else if (cell_size == '0) begin
      zq = top;
    end else if (div_quo > NW'(top)) begin
      zq = top;
    end else begin
      zq = div_quo[ZONE_W-1:0];
    end
  end

  // divider step
  assign div_trial = {div_rem[DVW-1:0], div_quo[NW-1]};
  assign div_ge    = div_trial >= {1'b0, div_d};

  // memory addressing
  assign a_addr  = a_idx[AW-1:0];
  assign e_waddr = e_idx[EW-1:0];
  assign e_addr  = (state == S_FIN_RD) ? e_j[EW-1:0] : e_idx[EW-1:0];

  always_ff @(posedge clk) begin
    key_q    <= asset_key[a_addr];
    azone_q  <= asset_zone[a_addr];
    ezones_q <= edge_zones[e_addr];
    ecount_q <= edge_count[e_addr];
    eprob_q  <= edge_prob[e_addr];
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      asset_fill <= '0;
      edge_fill  <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_kind    <= kind;
            cmd_id      <= asset_id;
            cmd_x       <= x_pos;
            cmd_y       <= y_pos;
            known       <= 1'b0;
            current_x   <= '0;
            current_y   <= '0;
            predicted_x <= '0;
            predicted_y <= '0;
            confidence  <= '0;
            a_idx       <= '0;
            e_idx       <= '0;
            case (kind)
              KIND_UPDATE: begin
                div_rem <= '0;
                div_quo <= NW'(x_pos);
                div_d   <= DVW'(cell_size);
                div_cnt <= CW'(NW);
                state   <= S_DIVX;
              end
              KIND_FINALIZE: state <= S_FOUT_RD;
              KIND_PREDICT:  state <= S_ARD;
              default:       done  <= 1'b1;
            endcase
          end
        end
        S_DIVX, S_DIVY, S_FDIV: begin
          if (div_cnt != '0) begin
            div_rem <= div_ge ? (div_trial - {1'b0, div_d}) : div_trial;
            div_quo <= {div_quo[NW-2:0], div_ge};
            div_cnt <= div_cnt - 1'b1;
          end else if (state == S_DIVX) begin
            zone_x  <= zq;
            div_rem <= '0;
            div_quo <= NW'(cmd_y);
            div_cnt <= CW'(NW);
            state   <= S_DIVY;
          end else if (state == S_DIVY) begin
            new_zone <= {zone_x, zq};
            state    <= S_ARD;
          end else begin
            edge_prob[e_waddr] <= div_quo[PROB_W-1:0];
            e_idx <= e_idx + 1'b1;
            state <= S_FOUT_RD;
          end
        end
        S_ARD: begin
          if (a_idx == asset_fill) begin
            if (cmd_kind == KIND_UPDATE && asset_fill != AIW'(ASSET_SLOTS)) begin
              asset_key[a_addr]  <= cmd_id;
              asset_zone[a_addr] <= new_zone;
              asset_fill <= asset_fill + 1'b1;
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_AMATCH;
          end
        end
        S_AMATCH: begin
          if (key_q == cmd_id) begin
            cur_zone  <= azone_q;
            best_zone <= azone_q;
            best_prob <= '0;
            if (cmd_kind == KIND_UPDATE) begin
              asset_zone[a_addr] <= new_zone;
              if (azone_q != new_zone) begin
                state <= S_ERD;
              end else begin
                done  <= 1'b1;
                state <= S_IDLE;
              end
            end else begin
              state <= S_PRD;
            end
          end else begin
            a_idx <= a_idx + 1'b1;
            state <= S_ARD;
          end
        end
        S_ERD: begin
          if (e_idx == edge_fill) begin
            if (edge_fill != EIW'(EDGE_SLOTS)) begin
              edge_zones[e_waddr] <= {cur_zone, new_zone};
              edge_count[e_waddr] <= COUNT_W'(1);
              edge_prob[e_waddr]  <= '0;
              edge_fill <= edge_fill + 1'b1;
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_EMATCH;
          end
        end
        S_EMATCH: begin
          if (ezones_q == {cur_zone, new_zone}) begin
            if (ecount_q != '1) begin
              edge_count[e_waddr] <= ecount_q + 1'b1;
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            e_idx <= e_idx + 1'b1;
            state <= S_ERD;
          end
        end
        S_FOUT_RD: begin
          if (e_idx == edge_fill) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_FOUT_LD;
          end
        end
        S_FOUT_LD: begin
          fin_origin <= ezones_q[2*ZW-1:ZW];
          fin_count  <= ecount_q;
          fin_total  <= '0;
          e_j        <= '0;
          state      <= S_FIN_RD;
        end
        S_FIN_RD: begin
          if (e_j == edge_fill) begin
            if (fin_total != '0) begin
              div_rem <= '0;
              div_quo <= {fin_count, {FRAC_W{1'b0}}};
              div_d   <= DVW'(fin_total);
              div_cnt <= CW'(NW);
              state   <= S_FDIV;
            end else begin
              e_idx <= e_idx + 1'b1;
              state <= S_FOUT_RD;
            end
          end else begin
            state <= S_FIN_ACC;
          end
        end
        S_FIN_ACC: begin
          if (ezones_q[2*ZW-1:ZW] == fin_origin) begin
            fin_total <= fin_total + TW'(ecount_q);
          end
          e_j   <= e_j + 1'b1;
          state <= S_FIN_RD;
        end
        S_PRD: begin
          if (e_idx == edge_fill) begin
            known       <= 1'b1;
            current_x   <= cur_zone[ZW-1:ZONE_W];
            current_y   <= cur_zone[ZONE_W-1:0];
            predicted_x <= best_zone[ZW-1:ZONE_W];
            predicted_y <= best_zone[ZONE_W-1:0];
            confidence  <= best_prob;
            done        <= 1'b1;
            state       <= S_IDLE;
          end else begin
            state <= S_PMATCH;
          end
        end
        S_PMATCH: begin
          if (ezones_q[2*ZW-1:ZW] == cur_zone && eprob_q > best_prob) begin
            best_prob <= eprob_q;
            best_zone <= ezones_q[ZW-1:0];
          end
          e_idx <= e_idx + 1'b1;
          state <= S_PRD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
